@@ hdl/kemt_pkg.sv @@
package kemt_pkg;

    // Default table geometry
    localparam int DEF_ENTRIES = 16;
    localparam int DEF_MAX_LEN = 32;

    // Operation codes on the request channel
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result kinds on the response channel
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } kemt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_POST
    } kemt_state_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic        char_wr;    // write one keyword byte into the selected cell
        logic        commit;     // append the selected cell to the table
        logic        surv_init;  // survivor bit given to a newly appended cell
        logic        compare;    // compare one needle byte in every cell
        logic        finish;     // the compared byte is the needle's last
        logic        scan;       // advance the result chain by one cell
        logic [7:0]  sym;
        logic [15:0] uidx;
    } kemt_cmd_t;

endpackage

@@ hdl/kemt_if.sv @@
interface kemt_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  symbol;
    logic [15:0] entry_index;
    logic        last;

    modport source (output valid, operation, symbol, entry_index, last, input ready);
    modport sink   (input valid, operation, symbol, entry_index, last, output ready);
endinterface

interface kemt_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic        found;
    logic [15:0] match_index;

    modport source (output valid, kind, status, found, match_index, input ready);
    modport sink   (input valid, kind, status, found, match_index, output ready);
endinterface

@@ hdl/keyword_exact_match_table.sv @@
// Exact-match keyword table.
// req (sink): operation, symbol, entry_index, last. A load streams keyword bytes,
// the byte marked last appends the entry with entry_index if it fits and the table
// has room. A query streams needle bytes; its last byte produces the answer.
// rsp (source): kind, status, found, match_index; one transaction per item
// marked last, none for other items.
// Sequencing: each accepted request moves to an execute state that compares or
// writes against the per-entry byte memory, whose read is registered. A load's
// last byte then goes to a post state that loads the output register. A query's
// last byte first passes through a scan state while the earliest match ripples
// down the chain of cells, then goes to the post state. Requests are taken only
// in the idle state, so the block does not accept the next request before it is
// through with the current one.
// The response sits in an output register; a new request is accepted while
// it waits. If the receiver stalls and a further result is ready, the block
// holds that result and stops accepting until the register frees.
// Reset empties the table, clears the query and load positions and drops
// any pending response.
module keyword_exact_match_table
    import kemt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    kemt_req_if.sink   req,
    kemt_rsp_if.source rsp
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kemt_state_t   state_reg;
    kemt_state_t   state_next;

    logic          itm_op_reg;
    logic [7:0]    itm_sym_reg;
    logic [15:0]   itm_uidx_reg;
    logic          itm_last_reg;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [PW-1:0] lpos_reg;
    logic [PW-1:0] lpos_next;
    logic [PW-1:0] qpos_reg;
    logic [PW-1:0] qpos_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [SW-1:0] scan_reg;
    logic [SW-1:0] scan_next;

    kemt_status_t  res_status_reg;
    kemt_status_t  res_status_next;
    logic          res_kind_reg;

    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [1:0]    out_status_reg;
    logic          out_found_reg;
    logic [15:0]   out_idx_reg;
    logic          out_load;

    logic          exec;
    logic          is_load;
    logic          full;
    logic          room;
    logic          ovf_eff;
    logic          scan_done;
    kemt_cmd_t     cmd;

    logic          cell_valid [ENTRIES];
    logic          cell_sel   [ENTRIES];
    logic          hit_chain  [ENTRIES + 1];
    logic [15:0]   idx_chain  [ENTRIES + 1];

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            itm_op_reg   <= req.operation;
            itm_sym_reg  <= req.symbol;
            itm_uidx_reg <= req.entry_index;
            itm_last_reg <= req.last;
        end
    end

    assign exec      = (state_reg == ST_EXEC);
    assign is_load   = (itm_op_reg == OP_LOAD);
    assign full      = (cnt_reg == CW'(ENTRIES));
    assign room      = (lpos_reg < PW'(MAX_LEN));
    assign ovf_eff   = ovf_reg || !room;
    assign scan_done = (scan_reg == SW'(ENTRIES - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!itm_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (is_load)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        req.ready     = 1'b0;
        out_load      = 1'b0;
        cmd.char_wr   = 1'b0;
        cmd.commit    = 1'b0;
        cmd.surv_init = (qpos_reg == '0);
        cmd.compare   = 1'b0;
        cmd.finish    = itm_last_reg;
        cmd.scan      = 1'b0;
        cmd.sym       = itm_sym_reg;
        cmd.uidx      = itm_uidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.char_wr = is_load && room && !full;
                cmd.commit  = is_load && itm_last_reg && !full && !ovf_eff;
                cmd.compare = !is_load;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_POST:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Advance load/query positions, entry count and load status
    always_comb
    begin
        cnt_next        = cnt_reg;
        lpos_next       = lpos_reg;
        qpos_next       = qpos_reg;
        ovf_next        = ovf_reg;
        res_status_next = res_status_reg;
        scan_next       = (state_reg == ST_SCAN) ? scan_reg + SW'(1) : '0;
        if (exec && is_load)
        begin
            if (itm_last_reg)
            begin
                lpos_next = '0;
                ovf_next  = 1'b0;
                if (full)
                begin
                    res_status_next = STATUS_FULL;
                end
                else if (ovf_eff)
                begin
                    res_status_next = STATUS_TOO_LONG;
                end
                else
                begin
                    res_status_next = STATUS_OK;
                    cnt_next        = cnt_reg + CW'(1);
                end
            end
            else
            begin
                ovf_next = ovf_eff;
                if (room)
                begin
                    lpos_next = lpos_reg + PW'(1);
                end
            end
        end
        else if (exec)
        begin
            res_status_next = STATUS_OK;
            if (itm_last_reg)
            begin
                qpos_next = '0;
            end
            else if (qpos_reg < PW'(MAX_LEN))
            begin
                qpos_next = qpos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            lpos_reg  <= '0;
            qpos_reg  <= '0;
            ovf_reg   <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lpos_reg  <= lpos_next;
            qpos_reg  <= qpos_next;
            ovf_reg   <= ovf_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        if (exec)
        begin
            res_kind_reg <= is_load ? KIND_LOAD : KIND_QUERY;
        end
    end

    // Row of cells, one per table entry
    assign hit_chain[0] = 1'b0;
    assign idx_chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign cell_valid[i] = (CW'(i) < cnt_reg);
        assign cell_sel[i]   = (CW'(i) == cnt_reg);

        kemt_cell #(
            .MAX_LEN (MAX_LEN)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .sel     (cell_sel[i]),
            .valid   (cell_valid[i]),
            .wr_pos  (lpos_reg),
            .rd_pos  (qpos_reg),
            .len_new (lpos_reg + PW'(1)),
            .hit_in  (hit_chain[i]),
            .idx_in  (idx_chain[i]),
            .hit_out (hit_chain[i + 1]),
            .idx_out (idx_chain[i + 1])
        );
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= res_kind_reg;
            if (res_kind_reg == KIND_QUERY)
            begin
                out_status_reg <= STATUS_OK;
                out_found_reg  <= hit_chain[ENTRIES];
                out_idx_reg    <= idx_chain[ENTRIES];
            end
            else
            begin
                out_status_reg <= res_status_reg;
                out_found_reg  <= 1'b0;
                out_idx_reg    <= '0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.match_index = out_idx_reg;

endmodule

@@ hdl/kemt_cell.sv @@
module kemt_cell
    import kemt_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    localparam int PW = $clog2(MAX_LEN + 1),
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  kemt_cmd_t     cmd,
    input  logic          sel,
    input  logic          valid,
    input  logic [PW-1:0] wr_pos,
    input  logic [PW-1:0] rd_pos,
    input  logic [PW-1:0] len_new,
    input  logic          hit_in,
    input  logic [15:0]   idx_in,
    output logic          hit_out,
    output logic [15:0]   idx_out
);

    logic [7:0]    mem [MAX_LEN];
    logic [7:0]    rd_reg;
    logic [PW-1:0] len_reg;
    logic [15:0]   uidx_reg;
    logic          surv_reg;
    logic          surv_next;
    logic          match_reg;
    logic          match_next;
    logic          hit_reg;
    logic          hit_next;
    logic [15:0]   idx_reg;
    logic [15:0]   idx_next;
    logic          keep;

    // Keyword bytes: one write port, one registered read at the query position
    always_ff @(posedge clk)
    begin
        if (cmd.char_wr && sel)
        begin
            mem[wr_pos[AW-1:0]] <= cmd.sym;
        end
        rd_reg <= mem[rd_pos[AW-1:0]];
    end

    // Latch length and user index when the entry is appended
    always_ff @(posedge clk)
    begin
        if (cmd.commit && sel)
        begin
            len_reg  <= len_new;
            uidx_reg <= cmd.uidx;
        end
    end

    // Keep the candidate only if the byte at this position agrees
    assign keep = (rd_pos < PW'(MAX_LEN)) && (rd_pos < len_reg) && (rd_reg == cmd.sym);

    // Update survivor and exact-match flags
    always_comb
    begin
        surv_next  = surv_reg;
        match_next = match_reg;
        if (cmd.commit && sel)
        begin
            surv_next = cmd.surv_init;
        end
        else if (cmd.compare)
        begin
            if (cmd.finish)
            begin
                surv_next  = 1'b1;
                match_next = valid && surv_reg && keep &&
                             ({1'b0, len_reg} == ({1'b0, rd_pos} + (PW + 1)'(1)));
            end
            else if (valid)
            begin
                surv_next = surv_reg && keep;
            end
        end
    end

    // Pass the earliest match down the chain, one cell per cycle
    always_comb
    begin
        hit_next = hit_reg;
        idx_next = idx_reg;
        if (cmd.scan)
        begin
            hit_next = hit_in || match_reg;
            if (hit_in)
            begin
                idx_next = idx_in;
            end
            else if (match_reg)
            begin
                idx_next = uidx_reg;
            end
            else
            begin
                idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surv_reg  <= 1'b1;
            match_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            surv_reg  <= surv_next;
            match_reg <= match_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign hit_out = hit_reg;
    assign idx_out = idx_reg;

endmodule

@@ hdl/kemt_chk.sv @@
module kemt_chk
    import kemt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_kind,
    input logic [1:0]  rsp_status,
    input logic        rsp_found,
    input logic [15:0] rsp_match_index
);

    // A pending response stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Two requests are never accepted back to back
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    // Query answers carry OK status and a zero index when nothing matched
    a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_QUERY) |->
            (rsp_status == STATUS_OK) && (rsp_found || (rsp_match_index == '0)))
        else $error("malformed query response");

    // Load answers never report a match and carry a known status
    a_load_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_LOAD) |->
            !rsp_found && (rsp_match_index == '0) &&
            ((rsp_status == STATUS_OK) || (rsp_status == STATUS_FULL) ||
             (rsp_status == STATUS_TOO_LONG)))
        else $error("malformed load response");

endmodule

bind keyword_exact_match_table kemt_chk u_kemt_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_kind        (rsp.kind),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_match_index (rsp.match_index)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kemt_pkg::*;

    localparam int ENTRIES     = DEF_ENTRIES;
    localparam int MAX_LEN     = DEF_MAX_LEN;
    localparam int TOTAL_ITEMS = 730;
    localparam int TAIL_START  = 640;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        operation;
        logic [7:0]  symbol;
        logic [15:0] entry_index;
        logic        last;
    } request_t;

    typedef struct packed {
        logic         kind;
        kemt_status_t status;
        logic         found;
        logic [15:0]  match_index;
    } answer_t;

    typedef logic [7:0] byte_q_t[$];

    // Shadow keyword table plus the queue of answers still owed by the block
    class answer_board;
        bit [7:0]         kw_bytes [ENTRIES][MAX_LEN];
        int               kw_len [ENTRIES];
        bit [15:0]        kw_tag [ENTRIES];
        int               stored;
        bit [ENTRIES-1:0] alive = '1;
        int               probe_pos;
        int               fill_pos;
        bit               spill;
        answer_t          pending[$];
        int               errors;

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        // Advance the shadow table by one accepted transaction
        function void note_request(request_t r);
            answer_t a;
            bit      hit;
            a = '0;
            hit = 1'b0;
            if (r.operation == OP_LOAD) begin
                if (fill_pos < MAX_LEN) begin
                    if (stored < ENTRIES)
                        kw_bytes[stored][fill_pos] = r.symbol;
                    fill_pos++;
                end
                else
                    spill = 1'b1;
                if (r.last) begin
                    a.kind = KIND_LOAD;
                    if (stored >= ENTRIES)
                        a.status = STATUS_FULL;
                    else if (spill)
                        a.status = STATUS_TOO_LONG;
                    else
                    begin
                        kw_len[stored] = fill_pos;
                        kw_tag[stored] = r.entry_index;
                        // an entry added mid-query sits out until that query ends
                        alive[stored] = (probe_pos == 0);
                        stored++;
                        a.status = STATUS_OK;
                    end
                    fill_pos = 0;
                    spill = 1'b0;
                    pending.push_back(a);
                end
            end
            else
            begin
                // drop every survivor that differs at this position or is too short
                for (int e = 0; e < stored; e++) begin
                    if (alive[e] && (probe_pos >= MAX_LEN || probe_pos >= kw_len[e] ||
                                     kw_bytes[e][probe_pos] != r.symbol))
                        alive[e] = 1'b0;
                end
                if (!r.last) begin
                    if (probe_pos < MAX_LEN)
                        probe_pos++;
                end
                else
                begin
                    a.kind = KIND_QUERY;
                    a.status = STATUS_OK;
                    for (int e = 0; e < stored; e++) begin
                        if (!hit && alive[e] && kw_len[e] == probe_pos + 1) begin
                            hit = 1'b1;
                            a.found = 1'b1;
                            a.match_index = kw_tag[e];
                        end
                    end
                    alive = '1;
                    probe_pos = 0;
                    pending.push_back(a);
                end
            end
        endfunction

        // Compare one received answer with the oldest one owed
        task check_answer(answer_t got);
            answer_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected response", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.found !== want.found)
                report_mismatch("found", got.found, want.found);
            if (got.match_index !== want.match_index)
                report_mismatch("match_index", got.match_index, want.match_index);
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kemt_req_if req_bus();
    kemt_rsp_if rsp_bus();

    answer_board board = new();
    int          items_sent;
    bit          quiet_tail;
    bit          long_hold;

    keyword_exact_match_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 7))
            0, 1: return 8'h61;
            2, 3: return 8'h62;
            4: return 8'h00;
            5: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic byte_q_t random_word(int len);
        byte_q_t w;
        for (int i = 0; i < len; i++)
            w.push_back(pick_symbol());
        return w;
    endfunction

    function automatic byte_q_t stored_word(int e);
        byte_q_t w;
        for (int i = 0; i < board.kw_len[e]; i++)
            w.push_back(board.kw_bytes[e][i]);
        return w;
    endfunction

    // Offer one transaction, with an optional idle burst ahead of it
    task automatic send_item(logic op, logic [7:0] sym, logic [15:0] tag, logic fin);
        request_t r;
        r = '{operation: op, symbol: sym, entry_index: tag, last: fin};
        if (!quiet_tail && !long_hold && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= op;
        req_bus.symbol      <= sym;
        req_bus.entry_index <= tag;
        req_bus.last        <= fin;
        do
            @(posedge clk);
        while (!req_bus.ready);
        board.note_request(r);
        items_sent++;
        if (items_sent >= TAIL_START)
            quiet_tail = 1'b1;
    endtask

    task automatic send_load(byte_q_t w, logic [15:0] tag);
        for (int i = 0; i < w.size(); i++)
            send_item(OP_LOAD, w[i], (i == w.size() - 1) ? tag : 16'($urandom),
                      i == w.size() - 1);
    endtask

    task automatic send_query(byte_q_t w);
        for (int i = 0; i < w.size(); i++)
            send_item(OP_QUERY, w[i], 16'($urandom), i == w.size() - 1);
    endtask

    // Response side: check, then pick the next ready with random stall bursts
    initial
    begin
        int      stall_left;
        int      answers_seen;
        bit      hold_done;
        answer_t got;
        stall_left = 0;
        answers_seen = 0;
        hold_done = 1'b0;
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.kind        = rsp_bus.kind;
                got.status      = kemt_status_t'(rsp_bus.status);
                got.found       = rsp_bus.found;
                got.match_index = rsp_bus.match_index;
                board.check_answer(got);
                answers_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!hold_done && answers_seen >= 25) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                long_hold = 1'b1;
            end
            if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                long_hold = 1'b0;
                if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                    rsp_bus.ready <= 1'b0;
                    stall_left = $urandom_range(1, 11) - 1;
                end
                else
                    rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Reset, directed transactions, random jobs, drain
    initial
    begin
        byte_q_t w;
        byte_q_t other;
        int      pick;
        int      cut;
        int      e;
        req_bus.valid       <= 1'b0;
        req_bus.operation   <= OP_LOAD;
        req_bus.symbol      <= 8'h00;
        req_bus.entry_index <= 16'h0000;
        req_bus.last        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // query an empty table
        send_item(OP_QUERY, 8'h61, 16'hFFFF, 1'b1);
        // fill with extremes of index and byte, plus a duplicate keyword
        send_item(OP_LOAD, 8'h61, 16'h0000, 1'b1);
        send_item(OP_LOAD, 8'h61, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'h62, 16'hFFFF, 1'b1);
        send_item(OP_LOAD, 8'h61, 16'hFFFF, 1'b0);
        send_item(OP_LOAD, 8'h62, 16'h1234, 1'b1);
        send_item(OP_LOAD, 8'hFF, 16'h8001, 1'b1);
        send_item(OP_LOAD, 8'h00, 16'h7FFE, 1'b1);
        // exact hit on the earliest duplicate, short hit, misses
        send_item(OP_QUERY, 8'h61, 16'h0000, 1'b0);
        send_item(OP_QUERY, 8'h62, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'h61, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'h62, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'h61, 16'h0000, 1'b0);
        send_item(OP_QUERY, 8'h62, 16'h0000, 1'b0);
        send_item(OP_QUERY, 8'h63, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'hFF, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'h00, 16'h0000, 1'b1);
        // load lands mid-query; old entries still match
        send_item(OP_QUERY, 8'h61, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'h7A, 16'h5555, 1'b1);
        send_item(OP_QUERY, 8'h62, 16'h0000, 1'b1);
        // new entry is excluded from the query in progress, then found
        send_item(OP_QUERY, 8'h71, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'h71, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'h72, 16'h2222, 1'b1);
        send_item(OP_QUERY, 8'h72, 16'h0000, 1'b1);
        send_item(OP_QUERY, 8'h71, 16'h0000, 1'b0);
        send_item(OP_QUERY, 8'h72, 16'h0000, 1'b1);

        // full-length keyword, its exact needle, an overlong needle, an overlong keyword
        w = random_word(MAX_LEN);
        send_load(w, 16'($urandom));
        send_query(w);
        w.push_back(pick_symbol());
        send_query(w);
        send_load(random_word(MAX_LEN + 2), 16'($urandom));

        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (board.stored == 0 || pick < 22) begin
                // append a keyword: short, full length, overlong or duplicate
                case ($urandom_range(0, 9))
                    0: w = random_word(MAX_LEN);
                    1: w = random_word($urandom_range(MAX_LEN + 1, MAX_LEN + 8));
                    2: w = (board.stored > 0) ?
                           stored_word($urandom_range(0, board.stored - 1)) :
                           random_word(2);
                    default: w = random_word($urandom_range(1, 5));
                endcase
                send_load(w, 16'($urandom));
            end
            else if (pick < 60) begin
                // needle from the table, exact or slightly off
                w = stored_word($urandom_range(0, board.stored - 1));
                case ($urandom_range(0, 9))
                    0, 1:
                        if (w.size() > 1)
                            repeat ($urandom_range(1, w.size() - 1)) void'(w.pop_back());
                    2, 3: repeat ($urandom_range(1, 3)) w.push_back(pick_symbol());
                    4: w[$urandom_range(0, w.size() - 1)] = pick_symbol();
                    default: ;
                endcase
                send_query(w);
            end
            else if (pick < 72) begin
                // query split by a complete load
                w = stored_word($urandom_range(0, board.stored - 1));
                if (w.size() < 2)
                    w.push_back(pick_symbol());
                cut = $urandom_range(1, w.size() - 1);
                for (int i = 0; i < cut; i++)
                    send_item(OP_QUERY, w[i], 16'($urandom), 1'b0);
                other = ($urandom_range(0, 1) == 0) ? w : random_word($urandom_range(1, 4));
                send_load(other, 16'($urandom));
                for (int i = cut; i < w.size(); i++)
                    send_item(OP_QUERY, w[i], 16'($urandom), i == w.size() - 1);
            end
            else if (pick < 80) begin
                // load split by a complete query
                w = random_word($urandom_range(2, 5));
                cut = $urandom_range(1, w.size() - 1);
                for (int i = 0; i < cut; i++)
                    send_item(OP_LOAD, w[i], 16'($urandom), 1'b0);
                send_query(stored_word($urandom_range(0, board.stored - 1)));
                for (int i = cut; i < w.size(); i++)
                    send_item(OP_LOAD, w[i], 16'($urandom), i == w.size() - 1);
            end
            else if (pick < 88) begin
                // needle at or past the maximum length
                e = -1;
                for (int i = 0; i < board.stored; i++)
                    if (board.kw_len[i] == MAX_LEN)
                        e = i;
                w = (e >= 0) ? stored_word(e) : random_word(MAX_LEN);
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 4)) w.push_back(pick_symbol());
                send_query(w);
            end
            else if (pick < 95)
                send_query(random_word($urandom_range(1, 5)));
            else
                send_item(1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        end
        req_bus.valid <= 1'b0;

        // drain, then let the block settle
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4 * ENTRIES) @(posedge clk);

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ keyword_exact_match_table.f @@
hdl/kemt_pkg.sv
hdl/kemt_if.sv
hdl/kemt_cell.sv
hdl/keyword_exact_match_table.sv
hdl/kemt_chk.sv
sim/testbench.sv
